### src/mbq_pkg.sv
// Shared types and constants for the multichannel biquad low-pass filter.
// Used by the coefficient register file, the channel lanes and the top level.
package mbq_pkg;

	localparam int MAX_CH        = 8;
	localparam int COEF_BITS     = 18;
	localparam int REG_BITS      = 3 * COEF_BITS;
	localparam int APB_DATA_BITS = 64;
	localparam int APB_ADDR_BITS = 6;
	localparam int IDX_LSB       = 3;
	localparam int IDX_BITS      = $clog2(MAX_CH);

	localparam int B0_LSB = 0;
	localparam int A1_LSB = COEF_BITS;
	localparam int A2_LSB = 2 * COEF_BITS;

	typedef logic [REG_BITS-1:0] coef_t;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_y;
	} lane_ctrl_t;

endpackage

### src/mbq_apb_regs.sv
// APB-style coefficient register file, one 54-bit packed word per channel.
// Depends on mbq_pkg for register widths and address layout.
module mbq_apb_regs
	import mbq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output coef_t                    coef [MAX_CH]
);

	coef_t               coef_q [MAX_CH];
	logic [IDX_BITS-1:0] idx;
	logic                wr_en;

	assign idx   = paddr[IDX_LSB +: IDX_BITS];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CH; i++) coef_q[i] <= '0;
		end else if (wr_en) begin
			coef_q[idx] <= pwdata[REG_BITS-1:0];
		end
	end

	assign prdata = APB_DATA_BITS'(coef_q[idx]);
	assign coef   = coef_q;

endmodule

### src/mbq_lane.sv
// One filter channel: feed-forward sum, numerator product, recursive update.
// Depends on mbq_pkg for coefficient layout and the lane control struct.
module mbq_lane
	import mbq_pkg::*;
#(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lane_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  coef_t                         coef,
	output logic signed [SAMPLE_BITS-1:0] filtered
);

	localparam int XS_W  = SAMPLE_BITS + 2;
	localparam int FF_W  = SAMPLE_BITS + 20;
	localparam int FB_W  = SAMPLE_BITS + 18;
	localparam int ACC_W = SAMPLE_BITS + 21;

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] YMAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] YMIN = -YMAX - ACC_W'(1);

	logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q;
	logic signed [XS_W-1:0]        xs, xs_s1;
	logic signed [FF_W-1:0]        ff, ff_s2;
	logic signed [FB_W-1:0]        p1, p2;
	logic signed [ACC_W-1:0]       acc, shifted;
	logic signed [SAMPLE_BITS-1:0] ysat;
	logic signed [COEF_BITS-1:0]   b0, a1, a2;

	assign b0 = coef[B0_LSB +: COEF_BITS];
	assign a1 = coef[A1_LSB +: COEF_BITS];
	assign a2 = coef[A2_LSB +: COEF_BITS];

	assign xs = XS_W'(sample) + (XS_W'(x1_q) <<< 1) + XS_W'(x2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
		end else if (ctrl.ld_s1) begin
			x1_q <= sample;
			x2_q <= x1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) xs_s1 <= xs;
	end

	assign ff = b0 * xs_s1;

	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) ff_s2 <= ff;
	end

	assign p1      = a1 * y1_q;
	assign p2      = a2 * y2_q;
	assign acc     = ACC_W'(ff_s2) - ACC_W'(p1) - ACC_W'(p2) + HALF;
	assign shifted = acc >>> COEF_FRAC_BITS;

	always_comb begin
		if (shifted > YMAX)      ysat = YMAX[SAMPLE_BITS-1:0];
		else if (shifted < YMIN) ysat = YMIN[SAMPLE_BITS-1:0];
		else                     ysat = shifted[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y1_q <= '0;
			y2_q <= '0;
		end else if (ctrl.ld_y) begin
			y1_q <= ysat;
			y2_q <= y1_q;
		end
	end

	assign filtered = y1_q;

endmodule

### src/multichannel_biquad_lowpass.sv
// Channel   | side    | word                      | handshake
// s_*       | slave   | MAX_CH samples            | s_tvalid / s_tready
// m_*       | master  | MAX_CH filtered samples   | m_tvalid / m_tready
// apb       | slave   | 64-bit coefficient words  | psel / penable, pready high
//
// One word per cycle unless m_tready stalls; stages valid_s1, valid_s2, then m_tvalid.
// The recursion closes in the last stage: two feedback products, sum, round, clamp.
// Reset clears coefficients and all input and output histories.
// Stalls back up stage by stage; empty stages still take words while m_tvalid waits.
// Top level: coefficient registers, CHANNELS filter lanes (at most MAX_CH) and the output word.
// Depends on mbq_pkg, mbq_apb_regs and mbq_lane.
module multichannel_biquad_lowpass
	import mbq_pkg::*;
#(
	parameter int CHANNELS       = 8,
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// sample_0 .. sample_7, SAMPLE_BITS each, sample_0 lowest
	input  logic [((MAX_CH*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// filtered_0 .. filtered_7, SAMPLE_BITS each, filtered_0 lowest
	output logic [((MAX_CH*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [APB_ADDR_BITS-1:0]                paddr,
	input  logic [APB_DATA_BITS-1:0]                pwdata,
	output logic [APB_DATA_BITS-1:0]                prdata,
	output logic                                    pready
);

	localparam int DATA_W = ((MAX_CH*SAMPLE_BITS+7)/8)*8;

	coef_t      coef [MAX_CH];
	lane_ctrl_t ctrl;
	logic       valid_s1, valid_s2, tvalid_q;
	logic       rdy1, rdy2, rdy3;
	logic [MAX_CH*SAMPLE_BITS-1:0] ypack;

	assign pready = 1'b1;

	mbq_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.coef    (coef)
	);

	assign rdy3       = !tvalid_q || m_tready;
	assign rdy2       = !valid_s2 || rdy3;
	assign rdy1       = !valid_s1 || rdy2;
	assign s_tready   = rdy1;
	assign ctrl.ld_s1 = s_tvalid && rdy1;
	assign ctrl.ld_s2 = valid_s1 && rdy2;
	assign ctrl.ld_y  = valid_s2 && rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			tvalid_q <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) tvalid_q <= valid_s2;
		end
	end

	for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
		if (c < CHANNELS) begin : g_on
			mbq_lane #(
				.SAMPLE_BITS    (SAMPLE_BITS),
				.COEF_FRAC_BITS (COEF_FRAC_BITS)
			) u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.sample   (s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
				.coef     (coef[c]),
				.filtered (ypack[c*SAMPLE_BITS +: SAMPLE_BITS])
			);
		end else begin : g_off
			assign ypack[c*SAMPLE_BITS +: SAMPLE_BITS] = '0;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = DATA_W'(ypack);

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted word did not enter first stage");

	a_s2_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rdy3) |=> m_tvalid)
		else $error("second stage word lost before output");

	a_no_needless_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");
`endif

endmodule

### dv/mbq_lowpass_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the multichannel biquad low-pass testbench: a per-channel
// direct form I predictor with its own coefficients and sample histories.
// Depends on mbq_pkg for the channel count and coefficient layout.
package mbq_lowpass_sb_pkg;
	import mbq_pkg::*;

	localparam int SMP_BITS  = 16;
	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = ((MAX_CH * SMP_BITS + 7) / 8) * 8;

	typedef logic [WORD_BITS-1:0] word_t;

	class lowpass_scoreboard;
		coef_t       coef[MAX_CH];
		shortint     x_d1[MAX_CH];
		shortint     x_d2[MAX_CH];
		shortint     y_d1[MAX_CH];
		shortint     y_d2[MAX_CH];
		word_t       filtered_due[$];
		int unsigned mismatches;

		function new();
			for (int ch = 0; ch < MAX_CH; ch++) begin
				coef[ch] = '0;
				x_d1[ch] = 0;
				x_d2[ch] = 0;
				y_d1[ch] = 0;
				y_d2[ch] = 0;
			end
			mismatches = 0;
		endfunction

		function void load_coef(int idx, logic [63:0] value);
			coef[idx] = value[REG_BITS-1:0];
		endfunction

		function int unsigned pending();
			return filtered_due.size();
		endfunction

		function void flag(string what, word_t want, word_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h, got %h", what, want, got);
		endfunction

		function shortint filter_lane(int ch, shortint x);
			longint b0, a1, a2, acc, r;
			b0  = longint'($signed(coef[ch][B0_LSB +: COEF_BITS]));
			a1  = longint'($signed(coef[ch][A1_LSB +: COEF_BITS]));
			a2  = longint'($signed(coef[ch][A2_LSB +: COEF_BITS]));
			acc = b0 * x + 2 * b0 * x_d1[ch] + b0 * x_d2[ch]
				- a1 * y_d1[ch] - a2 * y_d2[ch];
			// round half up, then clamp to the sample range
			r = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (r > 32767)
				r = 32767;
			else if (r < -32768)
				r = -32768;
			x_d2[ch] = x_d1[ch];
			x_d1[ch] = x;
			y_d2[ch] = y_d1[ch];
			y_d1[ch] = shortint'(r);
			return shortint'(r);
		endfunction

		function void note_samples(word_t samples);
			word_t filtered;
			filtered = '0;
			for (int ch = 0; ch < MAX_CH; ch++)
				filtered[ch*SMP_BITS +: SMP_BITS] =
					filter_lane(ch, shortint'(samples[ch*SMP_BITS +: SMP_BITS]));
			filtered_due.push_back(filtered);
		endfunction

		function void check_filtered(word_t got);
			word_t want;
			if (filtered_due.size() == 0) begin
				flag("unexpected word", '0, got);
				return;
			end
			want = filtered_due.pop_front();
			for (int ch = 0; ch < MAX_CH; ch++)
				if (got[ch*SMP_BITS +: SMP_BITS] !== want[ch*SMP_BITS +: SMP_BITS])
					flag($sformatf("filtered_%0d", ch),
						word_t'(want[ch*SMP_BITS +: SMP_BITS]),
						word_t'(got[ch*SMP_BITS +: SMP_BITS]));
		endfunction
	endclass

endpackage

### dv/tb_multichannel_biquad_lowpass.sv
`timescale 1ns / 100ps
// Testbench for multichannel_biquad_lowpass: directed and random sample words
// under random stalls on both streams, coefficient phases loaded over APB.
// Depends on mbq_pkg, mbq_lowpass_sb_pkg and the block's RTL.
module tb_multichannel_biquad_lowpass;
	import mbq_pkg::*;
	import mbq_lowpass_sb_pkg::*;

	localparam int PHASES      = 6;
	localparam int PHASE_WORDS = 130;

	localparam logic [31:0] DIRECTED[19] = '{
		32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h0001_0001, 32'hFFFF_FFFF,
		32'h7FFF_8000, 32'h8000_7FFF, 32'h0001_FFFF, 32'hFFFF_0003, 32'h0003_FFFD,
		32'hFFFD_0001, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h8000_8000, 32'h8000_8000,
		32'h0000_0000, 32'h0000_0000, 32'h5555_AAAA, 32'hAAAA_5555
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	// sample_0 .. sample_7, 16 bits each, sample_0 lowest
	word_t                    s_tdata;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	// filtered_0 .. filtered_7, 16 bits each, filtered_0 lowest
	word_t                    m_tdata;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	lowpass_scoreboard sb;
	logic              no_idle = 1'b0;
	int                rx_hold = 0;

	multichannel_biquad_lowpass i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [63:0] pack_coef(int b0, int a1, int a2);
		logic [9:0] hi;
		hi = 10'($urandom);
		return {hi, a2[17:0], a1[17:0], b0[17:0]};
	endfunction

	function automatic logic [63:0] rand_coef();
		int kind;
		int ext[4];
		kind = $urandom_range(0, 9);
		ext  = '{32'h1FFFF, 32'h20000, 0, 32'h3FFFF};
		if (kind < 6)
			return pack_coef($urandom_range(1, 16384), -$urandom_range(0, 131071),
				$urandom_range(0, 65535));
		if (kind < 9)
			return {$urandom, $urandom};
		return pack_coef(ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
			ext[$urandom_range(0, 3)]);
	endfunction

	function automatic word_t rand_samples();
		word_t w;
		int    kind;
		logic [15:0] ext[4];
		ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		for (int ch = 0; ch < MAX_CH; ch++) begin
			kind = $urandom_range(0, 9);
			if (kind < 6)
				w[ch*SMP_BITS +: SMP_BITS] = 16'($urandom);
			else if (kind == 6)
				w[ch*SMP_BITS +: SMP_BITS] = ext[$urandom_range(0, 3)];
			else
				w[ch*SMP_BITS +: SMP_BITS] = 16'($urandom_range(0, 512) - 256);
		end
		return w;
	endfunction

	function automatic word_t fill_pair(logic [31:0] pair);
		word_t w;
		for (int ch = 0; ch < MAX_CH; ch++)
			w[ch*SMP_BITS +: SMP_BITS] = ch[0] ? pair[15:0] : pair[31:16];
		return w;
	endfunction

	task automatic send_samples(word_t samples);
		int gap;
		gap = (!no_idle && $urandom_range(0, 99) < 30) ? gap_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom, $urandom, $urandom};
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= samples;
		do @(posedge clk); while (!s_tready);
	endtask

	// write one coefficient register, then read it back
	task automatic write_coef(int idx, logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_BITS'(idx << IDX_LSB);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.load_coef(idx, value);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		pwdata  <= '0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_BITS'(sb.coef[idx]))
			sb.flag($sformatf("coef_ch%0d readback", idx), word_t'(sb.coef[idx]),
				word_t'(prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (rx_hold != 0) begin
			m_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			m_tready <= 1'b1;
			if (!no_idle && $urandom_range(0, 99) < 25)
				rx_hold = gap_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_samples(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_filtered(m_tdata);
		end
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [63:0] setting;
		sb       = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// coefficients still at reset: outputs stay zero
		for (int i = 0; i < 3; i++)
			send_samples(rand_samples());

		wait_idle();
		write_coef(0, pack_coef(32'h08000, 0, 0));
		write_coef(1, pack_coef(32'h1FFFF, 32'h20000, 32'h1FFFF));
		write_coef(2, pack_coef(32'h20000, 32'h1FFFF, 32'h20000));
		write_coef(3, pack_coef(4424, -74907, 27054));
		write_coef(4, 64'hFFFF_FFFF_FFFF_FFFF);
		write_coef(5, pack_coef(32'h10000, 0, 0));
		write_coef(6, pack_coef(1, 32'h10000, 0));
		write_coef(7, 64'h0);
		foreach (DIRECTED[k])
			send_samples(fill_pair(DIRECTED[k]));

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			for (int ch = 0; ch < MAX_CH; ch++) begin
				if (p == 1)
					setting = 64'hFFFF_FFFF_FFFF_FFFF;
				else if (p == 3)
					setting = pack_coef(32'h1FFFF, 32'h1FFFF, 32'h1FFFF);
				else
					setting = rand_coef();
				write_coef(ch, setting);
			end
			for (int n = 0; n < PHASE_WORDS; n++) begin
				no_idle = (n >= 40 && n < 80);
				send_samples(rand_samples());
			end
			no_idle = 1'b0;
		end

		wait_idle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
